// ===== rtl/core/lffc_pkg.sv =====
// Shared types and constants for the light fade and flash controller.
// Holds the sequencer state, light phase, mode and register index codes.
// No dependencies.
package lffc_pkg;

	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;
	localparam int KIND_W    = 2;
	localparam int DT_W      = 16;
	localparam int DRAW_W    = 16;

	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_TICK  = 2'd0;
	localparam kind_t KIND_ACT   = 2'd1;
	localparam kind_t KIND_DEACT = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_MODE     = 3'd0;
	localparam cfg_idx_t REG_FADE_IN  = 3'd1;
	localparam cfg_idx_t REG_FADE_OUT = 3'd2;
	localparam cfg_idx_t REG_PERIOD   = 3'd3;
	localparam cfg_idx_t REG_ON_MIN   = 3'd4;
	localparam cfg_idx_t REG_ON_MAX   = 3'd5;
	localparam cfg_idx_t REG_OFF_MIN  = 3'd6;
	localparam cfg_idx_t REG_OFF_MAX  = 3'd7;

	typedef enum logic [1:0] {
		PH_OFF = 2'd0,
		PH_ON  = 2'd1,
		PH_IN  = 2'd2,
		PH_OUT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		MODE_CONST   = 2'd0,
		MODE_FLASH   = 2'd1,
		MODE_RANDOM  = 2'd2,
		MODE_ONESHOT = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_START,
		SEQ_FTICK,
		SEQ_MODE,
		SEQ_FLASH,
		SEQ_RSUB,
		SEQ_RSUB2,
		SEQ_MUL,
		SEQ_RADD,
		SEQ_LSET,
		SEQ_DIV,
		SEQ_LFIN,
		SEQ_DONE
	} seq_t;

	localparam logic [CFG_W-1:0] RST_FADE_IN  = 20'd50;
	localparam logic [CFG_W-1:0] RST_FADE_OUT = 20'd50;
	localparam logic [CFG_W-1:0] RST_PERIOD   = 20'd1000;
	localparam logic [CFG_W-1:0] RST_ON_MIN   = 20'd0;
	localparam logic [CFG_W-1:0] RST_ON_MAX   = 20'd100;
	localparam logic [CFG_W-1:0] RST_OFF_MIN  = 20'd0;
	localparam logic [CFG_W-1:0] RST_OFF_MAX  = 20'd300;

endpackage

// ===== rtl/core/lffc_alu.sv =====
// Shared adder/subtractor for the light fade and flash controller sequencer.
// Gives the sum or difference with carry out (carry set on subtract means a >= b).
// No dependencies.
module lffc_alu #(
	parameter int W = 21
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] res,
	output logic         carry
);

	assign {carry, res} = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);

endmodule

// ===== rtl/core/light_fade_flash_controller.sv =====
// Light fade and flash controller top level: register file, sequencer and state.
// Depends on lffc_pkg and lffc_alu.
//
// Each request (tick, activate or deactivate) is worked by a small sequencer that steps
// one shared adder/subtractor through the countdown updates, the random time draw
// (a bit-serial multiply, one draw bit a cycle) and the brightness fraction (a restoring
// division, one quotient bit a cycle). A request that leaves the light steadily on or off
// skips the division; a random time reload adds the range subtraction, the multiply and
// the add, and a reversed fade adds a multiply and a second fraction pass. A finished
// result waits in SEQ_DONE while the previous result still waits under out_stall.
// in_stall is high while a request is in work; the result sits in an output register,
// so a new request is taken while it still waits.
module light_fade_flash_controller #(
	parameter int TIME_BITS  = 20,
	parameter int LEVEL_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lffc_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [lffc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lffc_pkg::KIND_W-1:0]    kind,
	input  logic [lffc_pkg::DT_W-1:0]      elapsed,
	input  logic [lffc_pkg::DRAW_W-1:0]    random_draw,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [LEVEL_BITS:0]            level,
	output logic [1:0]                     light_state,
	output logic                           active,
	output logic                           needs_ticks,
	output logic                           finished
);
	import lffc_pkg::*;

	localparam int AW0 = (TIME_BITS > CFG_W + 1) ? TIME_BITS : CFG_W + 1;
	localparam int AW  = (AW0 > LEVEL_BITS + 1) ? AW0 : LEVEL_BITS + 1;
	localparam int MBW = (LEVEL_BITS > DRAW_W) ? LEVEL_BITS : DRAW_W;
	localparam int CW  = $clog2(MBW + 1);

	localparam logic [AW-1:0]         FULL_AW  = AW'(1) << LEVEL_BITS;
	localparam logic [LEVEL_BITS:0]   FULL_LV  = (LEVEL_BITS+1)'(1) << LEVEL_BITS;
	localparam logic [AW-1:0]         TMAX_AW  = AW'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [CW-1:0]         LB_CNT   = CW'(LEVEL_BITS);
	localparam logic [CW-1:0]         DRAW_CNT = CW'(DRAW_W);
	localparam logic [CW-1:0]         CNT_LAST = CW'(1);

	function automatic logic [TIME_BITS-1:0] sat_time(input logic [AW-1:0] v);
		if (v > TMAX_AW)
			return TMAX_AW[TIME_BITS-1:0];
		return v[TIME_BITS-1:0];
	endfunction

	seq_t state_q, state_d;

	mode_t            mode_q;
	logic [CFG_W-1:0] fade_in_q, fade_out_q, period_q;
	logic [CFG_W-1:0] on_min_q, on_max_q, off_min_q, off_max_q;

	phase_t                phase_q, phase_d;
	logic                  active_q, active_d;
	logic                  wanted_q, wanted_d;
	logic [TIME_BITS-1:0]  fade_left_q, fade_left_d;
	logic [TIME_BITS-1:0]  flash_left_q, flash_left_d;

	kind_t              kind_q, kind_d;
	logic [DT_W-1:0]    dt_q, dt_d;
	logic [DRAW_W-1:0]  draw_q, draw_d;
	logic               old_out_q, old_out_d;
	logic               done_q, done_d;
	logic               rev_q, rev_d;
	logic               mul_rnd_q, mul_rnd_d;
	logic               dir_q, dir_d;
	logic               zero_q, zero_d;
	logic [AW-1:0]      acc_q, acc_d;
	logic [AW-1:0]      opa_q, opa_d;
	logic [MBW-1:0]     mb_q, mb_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [LEVEL_BITS:0] qc_q, qc_d;
	logic [LEVEL_BITS:0] lvl_q, lvl_d;

	logic                out_valid_q, out_valid_d;
	logic [LEVEL_BITS:0] level_q;
	logic [1:0]          light_state_q;
	logic                active_out_q, wanted_out_q, finished_q;
	logic                out_load;

	logic [AW-1:0]    alu_a, alu_b, alu_res, div_x;
	logic             alu_sub, alu_carry, alu_zero, cnt_ends;
	logic [CFG_W-1:0] rlo, rhi, fdiv, rev_ticks;
	logic [LEVEL_BITS:0] frac;

	lffc_alu #(.W(AW)) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.res   (alu_res),
		.carry (alu_carry)
	);

	assign rlo       = (phase_q == PH_ON) ? on_min_q : off_min_q;
	assign rhi       = (phase_q == PH_ON) ? on_max_q : off_max_q;
	assign fdiv      = (phase_q == PH_OUT) ? fade_out_q : fade_in_q;
	assign rev_ticks = (phase_q == PH_OUT) ? fade_in_q : fade_out_q;
	assign div_x     = {acc_q[AW-2:0], 1'b0};
	assign alu_zero  = (alu_res == '0);
	assign cnt_ends  = !alu_carry || alu_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_CONST;
			fade_in_q  <= RST_FADE_IN;
			fade_out_q <= RST_FADE_OUT;
			period_q   <= RST_PERIOD;
			on_min_q   <= RST_ON_MIN;
			on_max_q   <= RST_ON_MAX;
			off_min_q  <= RST_OFF_MIN;
			off_max_q  <= RST_OFF_MAX;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MODE:     mode_q     <= mode_t'(cfg_data[1:0]);
				REG_FADE_IN:  fade_in_q  <= cfg_data;
				REG_FADE_OUT: fade_out_q <= cfg_data;
				REG_PERIOD:   period_q   <= cfg_data;
				REG_ON_MIN:   on_min_q   <= cfg_data;
				REG_ON_MAX:   on_max_q   <= cfg_data;
				REG_OFF_MIN:  off_min_q  <= cfg_data;
				REG_OFF_MAX:  off_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			SEQ_FTICK: begin
				alu_a   = AW'(fade_left_q);
				alu_b   = AW'(dt_q);
				alu_sub = 1'b1;
			end
			SEQ_FLASH: begin
				alu_a   = AW'(flash_left_q);
				alu_b   = AW'(dt_q);
				alu_sub = 1'b1;
			end
			SEQ_RSUB: begin
				alu_a   = AW'(rhi);
				alu_b   = AW'(rlo);
				alu_sub = 1'b1;
			end
			SEQ_RSUB2: begin
				alu_a   = AW'(rlo);
				alu_b   = AW'(rhi);
				alu_sub = 1'b1;
			end
			SEQ_MUL: begin
				alu_a = acc_q;
				alu_b = mb_q[0] ? opa_q : '0;
			end
			SEQ_RADD: begin
				alu_a   = AW'(rlo);
				alu_b   = acc_q;
				alu_sub = !dir_q;
			end
			SEQ_LSET: begin
				alu_a   = AW'(fade_left_q);
				alu_b   = AW'(fdiv);
				alu_sub = 1'b1;
			end
			SEQ_DIV: begin
				alu_a   = div_x;
				alu_b   = AW'(fdiv);
				alu_sub = 1'b1;
			end
			SEQ_LFIN: begin
				alu_a   = FULL_AW;
				alu_b   = AW'(qc_q);
				alu_sub = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		active_d     = active_q;
		wanted_d     = wanted_q;
		fade_left_d  = fade_left_q;
		flash_left_d = flash_left_q;
		kind_d       = kind_q;
		dt_d         = dt_q;
		draw_d       = draw_q;
		old_out_d    = old_out_q;
		done_d       = done_q;
		rev_d        = rev_q;
		mul_rnd_d    = mul_rnd_q;
		dir_d        = dir_q;
		zero_d       = zero_q;
		acc_d        = acc_q;
		opa_d        = opa_q;
		mb_d         = mb_q;
		cnt_d        = cnt_q;
		qc_d         = qc_q;
		lvl_d        = lvl_q;
		out_valid_d  = out_valid_q && out_stall;
		out_load     = 1'b0;
		frac         = '0;

		unique case (state_q)
			SEQ_IDLE: begin
				if (in_valid) begin
					kind_d    = kind;
					dt_d      = elapsed;
					draw_d    = random_draw;
					done_d    = 1'b0;
					old_out_d = (phase_q == PH_OUT);
					state_d   = SEQ_START;
				end
			end
			SEQ_START: begin
				rev_d   = 1'b0;
				state_d = SEQ_LSET;
				unique case (kind_q)
					KIND_TICK: begin
						state_d = (phase_q == PH_IN || phase_q == PH_OUT) ? SEQ_FTICK : SEQ_MODE;
					end
					KIND_ACT: begin
						if (!active_q) begin
							active_d = 1'b1;
							if (mode_q == MODE_CONST || mode_q == MODE_ONESHOT) begin
								wanted_d = 1'b1;
								unique case (phase_q)
									PH_OFF: begin
										fade_left_d = sat_time(AW'(fade_in_q));
										phase_d     = PH_IN;
									end
									PH_ON:  fade_left_d = '0;
									PH_OUT: rev_d = 1'b1;
									PH_IN:  ;
								endcase
							end
						end
					end
					KIND_DEACT: begin
						if (active_q) begin
							active_d = 1'b0;
							if (mode_q == MODE_CONST || mode_q == MODE_ONESHOT)
								wanted_d = 1'b1;
							else
								flash_left_d = '0;
							unique case (phase_q)
								PH_ON: begin
									fade_left_d = sat_time(AW'(fade_out_q));
									phase_d     = PH_OUT;
								end
								PH_OFF: fade_left_d = '0;
								PH_IN:  rev_d = 1'b1;
								PH_OUT: ;
							endcase
						end
					end
					default: ;
				endcase
			end
			SEQ_FTICK: begin
				if (cnt_ends) begin
					fade_left_d = '0;
					phase_d     = (phase_q == PH_OUT) ? PH_OFF : PH_ON;
				end else begin
					fade_left_d = alu_res[TIME_BITS-1:0];
				end
				state_d = SEQ_MODE;
			end
			SEQ_MODE: begin
				rev_d   = 1'b0;
				state_d = SEQ_LSET;
				unique case (mode_q)
					MODE_CONST: begin
						if (phase_q == PH_ON || phase_q == PH_OFF)
							wanted_d = 1'b0;
					end
					MODE_ONESHOT: begin
						if (phase_q == PH_ON) begin
							fade_left_d = sat_time(AW'(fade_out_q));
							phase_d     = PH_OUT;
						end else if (phase_q == PH_OFF) begin
							done_d   = old_out_q;
							wanted_d = 1'b0;
						end
					end
					MODE_FLASH, MODE_RANDOM: begin
						if (active_q && (phase_q == PH_ON || phase_q == PH_OFF)) begin
							if (flash_left_q == '0) begin
								if (mode_q == MODE_FLASH)
									flash_left_d = sat_time(AW'(period_q));
								else
									state_d = SEQ_RSUB;
							end else begin
								state_d = SEQ_FLASH;
							end
						end
					end
				endcase
			end
			SEQ_FLASH: begin
				if (cnt_ends) begin
					flash_left_d = '0;
					if (phase_q == PH_ON) begin
						fade_left_d = sat_time(AW'(fade_out_q));
						phase_d     = PH_OUT;
					end else begin
						fade_left_d = sat_time(AW'(fade_in_q));
						phase_d     = PH_IN;
					end
				end else begin
					flash_left_d = alu_res[TIME_BITS-1:0];
				end
				state_d = SEQ_LSET;
			end
			SEQ_RSUB, SEQ_RSUB2: begin
				if (state_q == SEQ_RSUB)
					dir_d = alu_carry;
				if (state_q == SEQ_RSUB2 || alu_carry) begin
					opa_d     = alu_res;
					acc_d     = '0;
					mb_d      = MBW'(draw_q);
					cnt_d     = DRAW_CNT;
					mul_rnd_d = 1'b1;
					state_d   = SEQ_MUL;
				end else begin
					state_d = SEQ_RSUB2;
				end
			end
			SEQ_MUL: begin
				acc_d = {alu_carry, alu_res[AW-1:1]};
				mb_d  = mb_q >> 1;
				cnt_d = cnt_q - CNT_LAST;
				if (cnt_q == CNT_LAST) begin
					if (mul_rnd_q) begin
						state_d = SEQ_RADD;
					end else begin
						fade_left_d = sat_time({alu_carry, alu_res[AW-1:1]});
						phase_d     = (phase_q == PH_OUT) ? PH_IN : PH_OUT;
						rev_d       = 1'b0;
						state_d     = SEQ_LSET;
					end
				end
			end
			SEQ_RADD: begin
				flash_left_d = sat_time(alu_res);
				state_d      = SEQ_LSET;
			end
			SEQ_LSET: begin
				if (phase_q == PH_ON || phase_q == PH_OFF) begin
					lvl_d   = (phase_q == PH_ON) ? FULL_LV : '0;
					state_d = SEQ_DONE;
				end else if (fdiv == '0) begin
					zero_d  = 1'b1;
					state_d = SEQ_LFIN;
				end else begin
					zero_d = 1'b0;
					if (alu_carry) begin
						qc_d    = FULL_LV;
						state_d = SEQ_LFIN;
					end else begin
						acc_d   = AW'(fade_left_q);
						qc_d    = '0;
						cnt_d   = LB_CNT;
						state_d = SEQ_DIV;
					end
				end
			end
			SEQ_DIV: begin
				acc_d = alu_carry ? alu_res : div_x;
				qc_d  = {qc_q[LEVEL_BITS-1:0], alu_carry};
				cnt_d = cnt_q - CNT_LAST;
				if (cnt_q == CNT_LAST)
					state_d = SEQ_LFIN;
			end
			SEQ_LFIN: begin
				if (!rev_q) begin
					if (zero_q)
						lvl_d = '0;
					else
						lvl_d = (phase_q == PH_OUT) ? qc_q : alu_res[LEVEL_BITS:0];
					state_d = SEQ_DONE;
				end else begin
					if (zero_q)
						frac = (phase_q == PH_OUT) ? FULL_LV : '0;
					else
						frac = alu_res[LEVEL_BITS:0];
					if (frac == FULL_LV) begin
						fade_left_d = sat_time(AW'(rev_ticks));
						phase_d     = (phase_q == PH_OUT) ? PH_IN : PH_OUT;
						rev_d       = 1'b0;
						state_d     = SEQ_LSET;
					end else begin
						opa_d     = AW'(rev_ticks);
						acc_d     = '0;
						mb_d      = MBW'(frac[LEVEL_BITS-1:0]);
						cnt_d     = LB_CNT;
						mul_rnd_d = 1'b0;
						state_d   = SEQ_MUL;
					end
				end
			end
			SEQ_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SEQ_IDLE;
			phase_q      <= PH_ON;
			active_q     <= 1'b1;
			wanted_q     <= 1'b1;
			fade_left_q  <= '0;
			flash_left_q <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= KIND_TICK;
			old_out_q    <= 1'b0;
			done_q       <= 1'b0;
			rev_q        <= 1'b0;
			mul_rnd_q    <= 1'b0;
			dir_q        <= 1'b0;
			zero_q       <= 1'b0;
			cnt_q        <= '0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			active_q     <= active_d;
			wanted_q     <= wanted_d;
			fade_left_q  <= fade_left_d;
			flash_left_q <= flash_left_d;
			out_valid_q  <= out_valid_d;
			kind_q       <= kind_d;
			old_out_q    <= old_out_d;
			done_q       <= done_d;
			rev_q        <= rev_d;
			mul_rnd_q    <= mul_rnd_d;
			dir_q        <= dir_d;
			zero_q       <= zero_d;
			cnt_q        <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		dt_q   <= dt_d;
		draw_q <= draw_d;
		acc_q  <= acc_d;
		opa_q  <= opa_d;
		mb_q   <= mb_d;
		qc_q   <= qc_d;
		lvl_q  <= lvl_d;
		if (out_load) begin
			level_q       <= lvl_q;
			light_state_q <= phase_q;
			active_out_q  <= active_q;
			wanted_out_q  <= wanted_q;
			finished_q    <= done_q;
		end
	end

	assign in_stall    = (state_q != SEQ_IDLE);
	assign out_valid   = out_valid_q;
	assign level       = level_q;
	assign light_state = light_state_q;
	assign active      = active_out_q;
	assign needs_ticks = wanted_out_q;
	assign finished    = finished_q;

endmodule
